[hdl/hrlt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlt_pkg
// Types and constants shared by the request line tokenizer modules.
// ----------------------------------------------------------------------------
package hrlt_pkg;

  localparam int NUM_METHODS     = 6;
  localparam int METHOD_CHARS_W  = 8;
  localparam logic [3:0] METHOD_NAME_MAX = 4'd8;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;

  // field kinds
  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_PATH    = 3'd1;
  localparam logic [2:0] KIND_KEY     = 3'd2;
  localparam logic [2:0] KIND_VALUE   = 3'd3;
  localparam logic [2:0] KIND_VERSION = 3'd4;
  localparam logic [2:0] KIND_DELIM   = 3'd5;

  // method codes
  localparam logic [2:0] METHOD_GET      = 3'd0;
  localparam logic [2:0] METHOD_OPTIONS  = 3'd1;
  localparam logic [2:0] METHOD_POST     = 3'd2;
  localparam logic [2:0] METHOD_PUT      = 3'd3;
  localparam logic [2:0] METHOD_DELETE   = 3'd4;
  localparam logic [2:0] METHOD_DOWNLOAD = 3'd5;
  localparam logic [2:0] METHOD_INVALID  = 3'd6;

  localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
    4'd3, 4'd7, 4'd4, 4'd3, 4'd6, 4'd8
  };

  localparam logic [7:0] METHOD_CHARS [NUM_METHODS][METHOD_CHARS_W] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
    '{"D", "O", "W", "N", "L", "O", "A", "D"}
  };

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_PATH    = 3'd1,
    PH_KEY     = 3'd2,
    PH_VALUE   = 3'd3,
    PH_VERSION = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] field_kind;
    logic       pair_done;
    logic       key_dropped;
    logic       line_done;
    logic       format_status;
    logic [2:0] method_code;
    logic [7:0] pair_total;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic clear;
  } meth_ctl_t;

endpackage

[hdl/hrlt_method.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlt_method
// Method name matcher: prefix flags per known name plus a byte count.
// ----------------------------------------------------------------------------
module hrlt_method
  import hrlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  meth_ctl_t  ctl,
  input  logic [7:0] data_byte,
  output logic [2:0] method_code
);

  logic [NUM_METHODS-1:0] flags_r, flags_nxt;
  logic [3:0]             len_r, len_nxt;

  always_comb begin
    flags_nxt = flags_r;
    len_nxt   = len_r;
    if (ctl.step) begin
      for (int i = 0; i < NUM_METHODS; i++) begin
        if (flags_r[i] && ((len_r >= METHOD_LEN[i]) ||
                           (METHOD_CHARS[i][len_r[2:0]] != data_byte))) begin
          flags_nxt[i] = 1'b0;
        end
      end
      if (len_r < METHOD_NAME_MAX) begin
        len_nxt = len_r + 4'd1;
      end
    end
  end

  // lowest matching index wins
  always_comb begin
    method_code = METHOD_INVALID;
    for (int i = NUM_METHODS - 1; i >= 0; i--) begin
      if (flags_nxt[i] && (len_nxt == METHOD_LEN[i])) begin
        method_code = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      flags_r <= '1;
      len_r   <= '0;
    end else if (ctl.step) begin
      flags_r <= flags_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

[hdl/hrlt_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlt_core
// Per-byte phase tracking, field tagging, pair counting and line status.
// ----------------------------------------------------------------------------
module hrlt_core
  import hrlt_pkg::*;
#(
  parameter int MAX_PAIRS = 255
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  in_item_t  item,
  output out_item_t result
);

  localparam logic [7:0] PAIR_LIMIT = 8'((MAX_PAIRS > 255) ? 255 : MAX_PAIRS);

  phase_t     phase_r, phase_nxt;
  logic [7:0] pair_count_r, pair_count_nxt;
  logic       key_nonempty_r, key_nonempty_nxt;
  logic       version_nonempty_r, version_nonempty_nxt;
  logic [2:0] kind;
  logic       pair_done;
  logic       meth_step;
  logic       bad;
  logic [7:0] b;
  meth_ctl_t  meth_ctl;
  logic [2:0] method_code;

  assign b = item.data_byte;

  always_comb begin
    phase_nxt            = phase_r;
    key_nonempty_nxt     = key_nonempty_r;
    version_nonempty_nxt = version_nonempty_r;
    kind                 = KIND_DELIM;
    pair_done            = 1'b0;
    meth_step            = 1'b0;
    unique case (phase_r)
      PH_METHOD: begin
        if (b == CH_SPACE) begin
          phase_nxt = PH_PATH;
        end else begin
          kind      = KIND_METHOD;
          meth_step = 1'b1;
        end
      end
      PH_PATH: begin
        if (b == CH_SPACE) begin
          phase_nxt = PH_VERSION;
        end else if (b == CH_QUEST) begin
          phase_nxt = PH_KEY;
        end else begin
          kind = KIND_PATH;
        end
      end
      PH_KEY: begin
        if (b == CH_EQUAL) begin
          phase_nxt        = PH_VALUE;
          key_nonempty_nxt = 1'b0;
        end else if (b == CH_SPACE) begin
          phase_nxt = PH_VERSION;
        end else begin
          kind             = KIND_KEY;
          key_nonempty_nxt = 1'b1;
        end
      end
      PH_VALUE: begin
        if (b == CH_AMP) begin
          pair_done        = 1'b1;
          phase_nxt        = PH_KEY;
          key_nonempty_nxt = 1'b0;
        end else if (b == CH_SPACE) begin
          pair_done = 1'b1;
          phase_nxt = PH_VERSION;
        end else begin
          kind      = KIND_VALUE;
          pair_done = item.line_last;
        end
      end
      default: begin
        kind                 = KIND_VERSION;
        version_nonempty_nxt = 1'b1;
      end
    endcase
  end

  always_comb begin
    pair_count_nxt = pair_count_r;
    if (pair_done && (pair_count_r < PAIR_LIMIT)) begin
      pair_count_nxt = pair_count_r + 8'd1;
    end
  end

  assign bad = (phase_nxt != PH_VERSION) || !version_nonempty_nxt;

  assign meth_ctl.step  = advance && meth_step;
  assign meth_ctl.clear = advance && item.line_last;

  hrlt_method u_method (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (meth_ctl),
    .data_byte   (b),
    .method_code (method_code)
  );

  always_comb begin
    result.out_byte      = b;
    result.field_kind    = kind;
    result.pair_done     = pair_done;
    result.key_dropped   = item.line_last && key_nonempty_nxt;
    result.line_done     = item.line_last;
    result.format_status = item.line_last && bad;
    result.method_code   = method_code;
    result.pair_total    = pair_count_nxt;
  end

  // line end returns everything to the start-of-line state
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && item.line_last)) begin
      phase_r            <= PH_METHOD;
      pair_count_r       <= '0;
      key_nonempty_r     <= 1'b0;
      version_nonempty_r <= 1'b0;
    end else if (advance) begin
      phase_r            <= phase_nxt;
      pair_count_r       <= pair_count_nxt;
      key_nonempty_r     <= key_nonempty_nxt;
      version_nonempty_r <= version_nonempty_nxt;
    end
  end

endmodule

[hdl/http_request_line_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_tokenizer
// Tags each byte of a request line and reports method, pairs and status.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and every byte gives exactly one result. A byte
// is held in an input register, classified by a single level of logic against
// the running line state, and the result moves into an output register when
// the output side can take it; the sustained rate is one byte per clock as
// long as the output side takes results. The per-line state (phase, method
// prefix flags, pair count) advances as each byte moves into the output
// register and returns to its start values after the byte marked last.
module http_request_line_tokenizer
  import hrlt_pkg::*;
#(
  parameter int MAX_PAIRS = 255
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [7:0] PAIR_LIMIT = 8'((MAX_PAIRS > 255) ? 255 : MAX_PAIRS);

  logic      item_valid_r;
  in_item_t  item_r;
  logic      out_valid_r;
  out_item_t out_r;
  out_item_t result;
  logic      advance;

  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  hrlt_core #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a byte leaving the input register always shows up as a result
  a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("advanced item did not reach the output register");

  // a good line can only end inside the version field
  a_ok_in_version: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.line_done && !out_data.format_status |->
      out_data.field_kind == KIND_VERSION)
    else $error("good status on a byte outside the version");

  a_drop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.key_dropped || out_data.format_status) |->
      out_data.line_done)
    else $error("line status flag set before line end");

  a_pair_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pair_total <= PAIR_LIMIT)
    else $error("pair count beyond its limit");

endmodule

[sim/tb_http_request_line_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_request_line_tokenizer
// Self-checking bench for the request line tokenizer.
// ----------------------------------------------------------------------------
// A short table of hand-written lines covers the corner cases. It is followed
// by random request lines: named and garbled methods, paths, queries with
// empty and odd keys, missing versions, cut-off lines and plain byte noise,
// plus one line with enough pairs to fill the pair counter. Every result is
// compared field by field against a cycle-free model of the per-line state,
// or against its own tag for a typed table row. Both sides idle and stall in
// turn, and the queue of expected tags is drained between phases.
// ----------------------------------------------------------------------------
module tb_http_request_line_tokenizer;
  import hrlt_pkg::*;

  localparam int         PAIR_MAX    = 255;
  localparam logic [7:0] PAIR_CAP    = (PAIR_MAX > 255) ? 8'd255 : 8'(PAIR_MAX);
  localparam int         PHASE_ITEMS = 280;
  localparam int         DIR_N       = 24;
  localparam logic       FMT_OK      = 1'b0;
  localparam logic       FMT_BAD     = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_last;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  // hand-written lines; a typed row carries its own expected tag
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // empty method, line ends at once
    '{8'h20, 1'b1, 1'b1, '{8'h20, KIND_DELIM, 1'b0, 1'b0, 1'b1, FMT_BAD,
                           METHOD_INVALID, 8'd0}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, KIND_METHOD, 1'b0, 1'b0, 1'b1, FMT_BAD,
                           METHOD_INVALID, 8'd0}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, KIND_METHOD, 1'b0, 1'b0, 1'b1, FMT_BAD,
                           METHOD_INVALID, 8'd0}},
    // "PUT ?=& X": empty key, empty trailing key
    '{"P", 1'b0, 1'b0, '0},
    '{"U", 1'b0, 1'b0, '0},
    '{"T", 1'b0, 1'b0, '0},
    '{" ", 1'b0, 1'b0, '0},
    '{"?", 1'b0, 1'b0, '0},
    '{"=", 1'b0, 1'b0, '0},
    '{"&", 1'b0, 1'b0, '0},
    '{" ", 1'b0, 1'b0, '0},
    '{"X", 1'b1, 1'b1, '{"X", KIND_VERSION, 1'b0, 1'b0, 1'b1, FMT_OK,
                         METHOD_PUT, 8'd1}},
    // "GET /?k=v": line ends inside a value
    '{"G", 1'b0, 1'b0, '0},
    '{"E", 1'b0, 1'b0, '0},
    '{"T", 1'b0, 1'b0, '0},
    '{" ", 1'b0, 1'b0, '0},
    '{"/", 1'b0, 1'b0, '0},
    '{"?", 1'b0, 1'b0, '0},
    '{"k", 1'b0, 1'b0, '0},
    '{"=", 1'b0, 1'b0, '0},
    '{"v", 1'b1, 1'b0, '0},
    // " ?k": trailing key dropped
    '{" ", 1'b0, 1'b0, '0},
    '{"?", 1'b0, 1'b0, '0},
    '{"k", 1'b1, 1'b0, '0}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // line state of the model
  phase_t     tk_phase;
  logic [5:0] tk_flags;
  logic [3:0] tk_mlen;
  logic [7:0] tk_pairs;
  logic       tk_key_seen;
  logic       tk_ver_seen;

  out_item_t  pending_tags[$];
  logic [7:0] line_bytes[$];
  int         idle_mode;
  int         fail_count;
  int         bytes_sent;
  int         tags_checked;
  int         lines_seen;
  int         lines_bad;
  int         keys_dropped;
  int         lines_saturated;
  logic [6:0] codes_seen;

  always #2 clk = ~clk;

  http_request_line_tokenizer #(.MAX_PAIRS(PAIR_MAX)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  function automatic void clear_line_state();
    tk_phase    = PH_METHOD;
    tk_flags    = '1;
    tk_mlen     = '0;
    tk_pairs    = '0;
    tk_key_seen = 1'b0;
    tk_ver_seen = 1'b0;
  endfunction

  function automatic out_item_t tokenize_byte(input in_item_t it);
    out_item_t  r;
    logic [7:0] b;
    logic       pair;
    int         i;
    r = '0;
    b = it.data_byte;
    pair = 1'b0;
    r.out_byte = b;
    r.field_kind = KIND_DELIM;
    case (tk_phase)
      PH_METHOD: begin
        if (b == CH_SPACE) begin
          tk_phase = PH_PATH;
        end else begin
          r.field_kind = KIND_METHOD;
          for (i = 0; i < NUM_METHODS; i++) begin
            if (tk_flags[i] && (tk_mlen >= METHOD_LEN[i] ||
                                METHOD_CHARS[i][tk_mlen[2:0]] != b))
              tk_flags[i] = 1'b0;
          end
          if (tk_mlen < METHOD_NAME_MAX) tk_mlen = tk_mlen + 4'd1;
        end
      end
      PH_PATH: begin
        if (b == CH_SPACE) tk_phase = PH_VERSION;
        else if (b == CH_QUEST) tk_phase = PH_KEY;
        else r.field_kind = KIND_PATH;
      end
      PH_KEY: begin
        if (b == CH_EQUAL) begin
          tk_phase = PH_VALUE;
          tk_key_seen = 1'b0;
        end else if (b == CH_SPACE) begin
          tk_phase = PH_VERSION;
        end else begin
          r.field_kind = KIND_KEY;
          tk_key_seen = 1'b1;
        end
      end
      PH_VALUE: begin
        if (b == CH_AMP) begin
          pair = 1'b1;
          tk_phase = PH_KEY;
          tk_key_seen = 1'b0;
        end else if (b == CH_SPACE) begin
          pair = 1'b1;
          tk_phase = PH_VERSION;
        end else begin
          r.field_kind = KIND_VALUE;
          pair = it.line_last;
        end
      end
      default: begin
        r.field_kind = KIND_VERSION;
        tk_ver_seen = 1'b1;
      end
    endcase
    if (pair && tk_pairs < PAIR_CAP) tk_pairs = tk_pairs + 8'd1;
    r.pair_done = pair;
    r.line_done = it.line_last;
    if (it.line_last) begin
      r.key_dropped = tk_key_seen;
      r.format_status = (tk_phase != PH_VERSION || !tk_ver_seen) ? FMT_BAD : FMT_OK;
    end
    // first name whose full length matched wins
    r.method_code = METHOD_INVALID;
    for (i = NUM_METHODS - 1; i >= 0; i--) begin
      if (tk_flags[i] && tk_mlen == METHOD_LEN[i]) r.method_code = 3'(i);
    end
    r.pair_total = tk_pairs;
    if (it.line_last) clear_line_state();
    return r;
  endfunction

  // random byte that avoids up to three delimiters
  function automatic logic [7:0] pick_byte(input logic [7:0] x1, input logic [7:0] x2,
                                           input logic [7:0] x3);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x1 || b == x2 || b == x3);
    return b;
  endfunction

  function automatic void build_line();
    int          sel;
    int          n;
    int          k;
    int          j;
    int          m;
    logic [7:0]  structural [4];
    logic [63:0] ver_txt;
    structural = '{CH_SPACE, CH_QUEST, CH_EQUAL, CH_AMP};
    ver_txt = "HTTP/1.1";
    line_bytes.delete();
    // plain noise, leaning on the delimiter characters
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 20);
      for (j = 0; j < n; j++)
        line_bytes.push_back($urandom_range(0, 1) ? structural[$urandom_range(0, 3)]
                                                  : 8'($urandom_range(0, 255)));
      return;
    end
    sel = $urandom_range(0, 11);
    m = $urandom_range(0, NUM_METHODS - 1);
    if (sel <= 7) begin
      m = sel % NUM_METHODS;
      for (j = 0; j < METHOD_LEN[m]; j++) line_bytes.push_back(METHOD_CHARS[m][j]);
    end else if (sel == 8) begin
      n = $urandom_range(1, 12);
      for (j = 0; j < n; j++) line_bytes.push_back(pick_byte(CH_SPACE, CH_SPACE, CH_SPACE));
    end else if (sel == 9) begin
      for (j = 0; j < METHOD_LEN[m]; j++) line_bytes.push_back(METHOD_CHARS[m][j]);
      line_bytes[$urandom_range(0, METHOD_LEN[m] - 1)] = pick_byte(CH_SPACE, CH_SPACE,
                                                                   CH_SPACE);
    end else if (sel == 11) begin
      // one byte too many: no match, longest name saturates the length
      for (j = 0; j < METHOD_LEN[m]; j++) line_bytes.push_back(METHOD_CHARS[m][j]);
      line_bytes.push_back(pick_byte(CH_SPACE, CH_SPACE, CH_SPACE));
    end
    line_bytes.push_back(CH_SPACE);
    line_bytes.push_back("/");
    n = $urandom_range(0, 6);
    for (j = 0; j < n; j++) line_bytes.push_back(pick_byte(CH_SPACE, CH_QUEST, CH_QUEST));
    if ($urandom_range(0, 99) < 65) begin
      line_bytes.push_back(CH_QUEST);
      n = $urandom_range(0, 4);
      for (k = 0; k < n; k++) begin
        if (k != 0) line_bytes.push_back(CH_AMP);
        // keys may hold '&'
        m = $urandom_range(0, 3);
        for (j = 0; j < m; j++) line_bytes.push_back($urandom_range(0, 4) == 0 ? CH_AMP :
                                                     pick_byte(CH_SPACE, CH_EQUAL, CH_EQUAL));
        line_bytes.push_back(CH_EQUAL);
        m = $urandom_range(0, 4);
        for (j = 0; j < m; j++) line_bytes.push_back(pick_byte(CH_SPACE, CH_AMP, CH_AMP));
      end
      sel = $urandom_range(0, 3);
      if (sel == 0) begin
        if (n != 0) line_bytes.push_back(CH_AMP);
        m = $urandom_range(1, 3);
        for (j = 0; j < m; j++) line_bytes.push_back(pick_byte(CH_SPACE, CH_EQUAL, CH_EQUAL));
      end else if (sel == 1 && n != 0) begin
        line_bytes.push_back(CH_AMP);
      end
    end
    line_bytes.push_back(CH_SPACE);
    sel = $urandom_range(0, 9);
    if (sel <= 6) begin
      for (j = 0; j < 8; j++) line_bytes.push_back(ver_txt[8 * (7 - j) +: 8]);
    end else if (sel == 8) begin
      n = $urandom_range(1, 10);
      for (j = 0; j < n; j++) line_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (line_bytes.size() > 1 && $urandom_range(0, 99) < 12)
      line_bytes = line_bytes[0:$urandom_range(0, line_bytes.size() - 2)];
    // an empty line still needs a last byte
    if (line_bytes.size() == 0) line_bytes.push_back(CH_SPACE);
  endfunction

  function automatic void build_full_pairs_line();
    int j;
    line_bytes.delete();
    for (j = 0; j < 3; j++) line_bytes.push_back(METHOD_CHARS[METHOD_GET][j]);
    line_bytes.push_back(CH_SPACE);
    line_bytes.push_back("/");
    line_bytes.push_back(CH_QUEST);
    for (j = 0; j < 258; j++) begin
      line_bytes.push_back(CH_EQUAL);
      line_bytes.push_back(CH_AMP);
    end
    line_bytes.push_back(CH_SPACE);
    line_bytes.push_back("H");
  endfunction

  function automatic int sender_idle_pct();
    return idle_mode == 1 ? 86 : idle_mode == 3 ? 35 : 0;
  endfunction

  // offer one byte and wait for its transfer
  task automatic send_byte(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t tag;
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    tag = tokenize_byte(it);
    pending_tags.push_back(typed ? want : tag);
    bytes_sent++;
  endtask

  task automatic send_line();
    int j;
    for (j = 0; j < line_bytes.size(); j++)
      send_byte('{line_bytes[j], j == line_bytes.size() - 1}, 1'b0, '0);
  endtask

  task automatic drain_tags();
    in_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      case (idle_mode)
        2:       out_ready <= $urandom_range(0, 99) >= 86;
        3:       out_ready <= $urandom_range(0, 99) >= 35;
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tags.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: byte=%h kind=%0d", out_data.out_byte,
                   out_data.field_kind);
        fail_count++;
      end else begin
        want = pending_tags.pop_front();
        tags_checked++;
        if (out_data.out_byte !== want.out_byte || out_data.field_kind !== want.field_kind ||
            out_data.pair_done !== want.pair_done ||
            out_data.key_dropped !== want.key_dropped ||
            out_data.line_done !== want.line_done ||
            out_data.format_status !== want.format_status ||
            out_data.method_code !== want.method_code ||
            out_data.pair_total !== want.pair_total) begin
          if (fail_count < 10) begin
            $display("mismatch exp: byte=%h kind=%0d pd=%b kd=%b ld=%b fs=%b mc=%0d pt=%0d",
                     want.out_byte, want.field_kind, want.pair_done, want.key_dropped,
                     want.line_done, want.format_status, want.method_code, want.pair_total);
            $display("         got: byte=%h kind=%0d pd=%b kd=%b ld=%b fs=%b mc=%0d pt=%0d",
                     out_data.out_byte, out_data.field_kind, out_data.pair_done,
                     out_data.key_dropped, out_data.line_done, out_data.format_status,
                     out_data.method_code, out_data.pair_total);
          end
          fail_count++;
        end
        if (want.line_done) begin
          lines_seen++;
          codes_seen[want.method_code] = 1'b1;
          if (want.format_status == FMT_BAD) lines_bad++;
          if (want.key_dropped) keys_dropped++;
          if (want.pair_total == PAIR_CAP) lines_saturated++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", pending_tags.size());
    $display("** http_request_line_tokenizer: FAILED **");
    $finish;
  end

  initial begin
    int start;
    int j;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    idle_mode = 0;
    fail_count = 0;
    bytes_sent = 0;
    tags_checked = 0;
    lines_seen = 0;
    lines_bad = 0;
    keys_dropped = 0;
    lines_saturated = 0;
    codes_seen = '0;
    clear_line_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (j = 0; j < DIR_N; j++)
      send_byte('{DIR_TAB[j].data_byte, DIR_TAB[j].line_last}, DIR_TAB[j].typed,
                DIR_TAB[j].want);

    // no idling, sender idle, receiver stall, both
    for (idle_mode = 0; idle_mode < 4; idle_mode++) begin
      if (idle_mode == 0) begin
        build_full_pairs_line();
        send_line();
      end
      start = bytes_sent;
      while (bytes_sent - start < PHASE_ITEMS) begin
        build_line();
        send_line();
      end
      // sender holds off until every tag is back
      drain_tags();
    end

    repeat (16) @(posedge clk);
    if (pending_tags.size() != 0) begin
      $display("%0d expected results never arrived", pending_tags.size());
      fail_count++;
    end
    $display("%0d bytes in %0d lines checked (%0d bad format, %0d dropped keys)",
             tags_checked, lines_seen, lines_bad, keys_dropped);
    $display("method codes seen %b, pair counter full on %0d lines, %0d failures",
             codes_seen, lines_saturated, fail_count);
    if (fail_count == 0) begin
      $display("** http_request_line_tokenizer: PASSED **");
    end else begin
      $display("** http_request_line_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/hrlt_pkg.sv
hdl/hrlt_method.sv
hdl/hrlt_core.sv
hdl/http_request_line_tokenizer.sv
sim/tb_http_request_line_tokenizer.sv
